### rtl/core/asc_sort_pkg.sv
// Shared widths, types and defaults for the ascending integer sorter.
package asc_sort_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned MAX_ITEMS_DEF = 16;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;     // place the broadcast value into the sorted chain
        logic shift_out;  // move every entry one cell toward the head
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

### rtl/core/asc_sort_cell.sv
// One compare-and-insert cell of the sorting chain.
module asc_sort_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  asc_sort_pkg::cell_ctl_t               ctl,
    input  logic signed [asc_sort_pkg::DATA_W-1:0] new_value,
    input  logic signed [asc_sort_pkg::DATA_W-1:0] left_value,
    input  logic                                  left_valid,
    input  logic                                  left_bigger,
    input  logic signed [asc_sort_pkg::DATA_W-1:0] right_value,
    input  logic                                  right_valid,
    output logic signed [asc_sort_pkg::DATA_W-1:0] value,
    output logic                                  valid,
    output logic                                  bigger
);

    logic signed [asc_sort_pkg::DATA_W-1:0] value_reg, value_next;
    logic                                   valid_reg, valid_next;

    // An empty cell counts as larger than anything, so the chain stays packed.
    assign bigger = !valid_reg || (value_reg > new_value);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.insert) begin
            if (left_bigger) begin
                value_next = left_value;
                valid_next = left_valid;
            end else if (bigger) begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end else if (ctl.shift_out) begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

### rtl/core/ascending_integer_sorter_core.sv
// Top level of the ascending integer sorter: a chain of insertion cells.
//
// Input channel (s_valid/s_ready): one signed 32-bit element per transaction;
// s_last_item marks the final element of a set. While loading, one element
// is accepted every cycle; each one is inserted into the cell chain in the
// cycle it arrives, so the chain is always sorted. Elements that arrive when
// MAX_ITEMS are already held are dropped and flag overflow for the set.
// After the last element the chain drains toward its head: one result per
// cycle on the m_ channel, smallest first, m_last_result on the largest,
// m_overflow on every result of a set that lost elements.
// While a set drains, s_ready stays low; the first result goes into the
// output register after the last element is taken, and the rest follow
// one per cycle while the receiver accepts them. The
// throughput is set by the single shared shift path of the chain.
// If the receiver stalls, the chain holds and the output register keeps
// its transaction. Reset empties the chain, clears the count and the
// overflow flag and returns to loading; no clearing pass is needed.
module ascending_integer_sorter_core #(
    parameter int unsigned MAX_ITEMS = asc_sort_pkg::MAX_ITEMS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [asc_sort_pkg::DATA_W-1:0] s_item_value,
    input  logic                                   s_last_item,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [asc_sort_pkg::DATA_W-1:0] m_sorted_value,
    output logic                                   m_last_result,
    output logic                                   m_overflow
);

    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

    asc_sort_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    ovf_reg, ovf_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [asc_sort_pkg::DATA_W-1:0] m_value_reg, m_value_next;
    logic                    m_last_reg, m_last_next;
    logic                    m_ovf_reg, m_ovf_next;

    asc_sort_pkg::cell_ctl_t ctl;
    logic                    in_fire, store_full, out_load, out_final;

    logic signed [asc_sort_pkg::DATA_W-1:0] cell_value [MAX_ITEMS];
    logic                    cell_valid  [MAX_ITEMS];
    logic                    cell_bigger [MAX_ITEMS];

    assign s_ready    = (state_reg == asc_sort_pkg::ST_LOAD);
    assign in_fire    = s_valid && s_ready;
    assign store_full = (count_reg == CNT_W'(MAX_ITEMS));
    assign out_load   = (state_reg == asc_sort_pkg::ST_DRAIN) && (!m_valid_reg || m_ready);
    assign out_final  = !cell_valid[1];

    assign ctl.insert    = in_fire && !store_full;
    assign ctl.shift_out = out_load;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            logic signed [asc_sort_pkg::DATA_W-1:0] lv, rv;
            logic lval, lbig, rval;
            if (gi == 0) begin : g_head
                assign lv   = '0;
                assign lval = 1'b0;
                assign lbig = 1'b0;
            end else begin : g_mid
                assign lv   = cell_value[gi-1];
                assign lval = cell_valid[gi-1];
                assign lbig = cell_bigger[gi-1];
            end
            if (gi == MAX_ITEMS - 1) begin : g_tail
                assign rv   = '0;
                assign rval = 1'b0;
            end else begin : g_inner
                assign rv   = cell_value[gi+1];
                assign rval = cell_valid[gi+1];
            end
            asc_sort_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (ctl),
                .new_value   (s_item_value),
                .left_value  (lv),
                .left_valid  (lval),
                .left_bigger (lbig),
                .right_value (rv),
                .right_valid (rval),
                .value       (cell_value[gi]),
                .valid       (cell_valid[gi]),
                .bigger      (cell_bigger[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            asc_sort_pkg::ST_LOAD: begin
                if (in_fire) begin
                    if (store_full) begin
                        ovf_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_last_item) begin
                        count_next = '0;
                        state_next = asc_sort_pkg::ST_DRAIN;
                    end
                end
            end
            asc_sort_pkg::ST_DRAIN: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_value_next = cell_value[0];
                    m_last_next  = out_final;
                    m_ovf_next   = ovf_reg;
                    if (out_final) begin
                        ovf_next   = 1'b0;
                        state_next = asc_sort_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = asc_sort_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= asc_sort_pkg::ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_value_reg;
    assign m_last_result  = m_last_reg;
    assign m_overflow     = m_ovf_reg;

    // While draining, the head of the chain always holds a result.
    a_head_valid_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == asc_sort_pkg::ST_DRAIN) |-> cell_valid[0])
        else $error("drain with empty chain head");

    // The second cell is occupied only when the head is, so no gap opens at the chain head.
    a_chain_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_valid[1] |-> cell_valid[0])
        else $error("gap at the chain head");

    // The stored count never passes the chain length.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("element count beyond capacity");

    // Loading the final result of a set returns the block to loading and marks that result last.
    a_final_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_final) |=> (state_reg == asc_sort_pkg::ST_LOAD) && m_last_reg)
        else $error("final result did not end the drain");

endmodule

### tb/sorted_set_checker.sv
// Checker for the ascending integer sorter: predicts each sorted set and compares the results.
module sorted_set_checker #(
    parameter int unsigned MAX_ITEMS = asc_sort_pkg::MAX_ITEMS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic signed [asc_sort_pkg::DATA_W-1:0] s_item_value,
    input  logic                                   s_last_item,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic signed [asc_sort_pkg::DATA_W-1:0] m_sorted_value,
    input  logic                                   m_last_result,
    input  logic                                   m_overflow,
    output int                                     mismatch_count,
    output int                                     pending_results
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [asc_sort_pkg::DATA_W-1:0] value;
        logic                                   last;
        logic                                   ovf;
    } sorted_result_t;

    logic signed [asc_sort_pkg::DATA_W-1:0] set_elems_q[$];
    logic                                   set_dropped = 1'b0;
    sorted_result_t                         sorted_results_q[$];
    int                                     error_total = 0;

    // Bubble sort of the collected set; only strictly greater neighbors swap.
    function automatic void queue_sorted_set();
        logic signed [asc_sort_pkg::DATA_W-1:0] elems[$];
        logic signed [asc_sort_pkg::DATA_W-1:0] tmp;
        sorted_result_t                         res;
        elems = set_elems_q;
        for (int p = 0; p + 1 < elems.size(); p++) begin
            for (int k = 0; k + 1 < elems.size() - p; k++) begin
                if (elems[k] > elems[k+1]) begin
                    tmp        = elems[k];
                    elems[k]   = elems[k+1];
                    elems[k+1] = tmp;
                end
            end
        end
        foreach (elems[k]) begin
            res.value = elems[k];
            res.last  = (k == elems.size() - 1);
            res.ovf   = set_dropped;
            sorted_results_q.push_back(res);
        end
        set_elems_q.delete();
        set_dropped = 1'b0;
    endfunction

    function automatic void report(input string what, input longint exp_v, input longint act_v);
        error_total++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    endfunction

    always @(posedge aclk) begin
        sorted_result_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (sorted_results_q.size() == 0) begin
                    error_total++;
                    $display("%0t: unexpected result transaction, expected none, actual %0d",
                             $time, m_sorted_value);
                end else begin
                    exp_r = sorted_results_q.pop_front();
                    if (m_sorted_value !== exp_r.value) begin
                        report("sorted_value", exp_r.value, m_sorted_value);
                    end
                    if (m_last_result !== exp_r.last) begin
                        report("last_result", exp_r.last, m_last_result);
                    end
                    if (m_overflow !== exp_r.ovf) begin
                        report("overflow", exp_r.ovf, m_overflow);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (set_elems_q.size() < MAX_ITEMS) begin
                    set_elems_q.push_back(s_item_value);
                end else begin
                    set_dropped = 1'b1;
                end
                if (s_last_item) begin
                    queue_sorted_set();
                end
            end
        end
        mismatch_count  <= error_total;
        pending_results <= sorted_results_q.size();
    end

endmodule

### tb/ascending_integer_sorter_core_tb.sv
// Testbench top for the ascending integer sorter: stimulus, receiver stalls and the verdict.
module ascending_integer_sorter_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SET_CAP       = asc_sort_pkg::MAX_ITEMS_DEF;
    localparam int          RANDOM_ITEMS  = 220;
    localparam int          HOLDOFF_LEN   = 64;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          IDLE_PCT      = 23;
    localparam logic signed [asc_sort_pkg::DATA_W-1:0] MAX_VAL =
        {1'b0, {(asc_sort_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [asc_sort_pkg::DATA_W-1:0] MIN_VAL =
        {1'b1, {(asc_sort_pkg::DATA_W-1){1'b0}}};

    logic                                   aclk           = 1'b0;
    logic                                   aresetn        = 1'b0;
    logic                                   s_valid        = 1'b0;
    logic                                   s_ready;
    logic signed [asc_sort_pkg::DATA_W-1:0] s_item_value   = '0;
    logic                                   s_last_item    = 1'b0;
    logic                                   m_valid;
    logic                                   m_ready        = 1'b0;
    logic signed [asc_sort_pkg::DATA_W-1:0] m_sorted_value;
    logic                                   m_last_result;
    logic                                   m_overflow;

    int   mismatch_count;
    int   pending_results;
    int   idle_cycles    = 0;
    int   items_sent     = 0;
    logic quiet          = 1'b0;
    logic holdoff_req    = 1'b0;

    always #5 aclk = ~aclk;

    ascending_integer_sorter_core #(
        .MAX_ITEMS (SET_CAP)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item_value   (s_item_value),
        .s_last_item    (s_last_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_last_result  (m_last_result),
        .m_overflow     (m_overflow)
    );

    sorted_set_checker #(
        .MAX_ITEMS (SET_CAP)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item_value    (s_item_value),
        .s_last_item     (s_last_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sorted_value  (m_sorted_value),
        .m_last_result   (m_last_result),
        .m_overflow      (m_overflow),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_item(input logic signed [asc_sort_pkg::DATA_W-1:0] value,
                             input logic last);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_item_value <= value;
        s_last_item  <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    function automatic logic signed [asc_sort_pkg::DATA_W-1:0] pick_value(input int mode);
        int unsigned r;
        r = $urandom_range(0, 4);
        case (mode)
            1: return int'($urandom_range(0, 8)) - 4;
            2: begin
                case (r)
                    0: return MAX_VAL;
                    1: return MIN_VAL;
                    2: return '0;
                    3: return -1;
                    default: return $urandom();
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic send_set(input int n, input int mode);
        for (int i = 0; i < n; i++) begin
            send_item(pick_value(mode), i == n - 1);
        end
    endtask

    // Sender: directed sets first, then random sets of mixed sizes and value styles.
    initial begin
        int unsigned pick;
        int          set_len;
        int          set_no;
        set_no = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(MAX_VAL, 1'b1);
        send_item(MIN_VAL, 1'b0);
        send_item(MAX_VAL, 1'b0);
        send_item('0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b1);
        // Overfull set: the last two are dropped, the dropped last item still ends the set.
        for (int i = 0; i < SET_CAP + 2; i++) begin
            send_item(i[0] ? 32'sh5555_5555 - i : 32'shAAAA_AAAA + i, i == SET_CAP + 1);
        end

        while (items_sent < RANDOM_ITEMS) begin
            if (set_no == 2) begin
                holdoff_req <= 1'b1;
            end
            quiet <= (items_sent >= 110 && items_sent < 160);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                set_len = SET_CAP;
            end else if (pick < 22) begin
                set_len = $urandom_range(SET_CAP + 1, SET_CAP + 4);
            end else if (pick < 37) begin
                set_len = $urandom_range(1, 3);
            end else begin
                set_len = $urandom_range(1, SET_CAP);
            end
            send_set(set_len, $urandom_range(0, 2));
            set_no++;
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Receiver: random stalls, none during the quiet stretch, and one long hold-off.
    initial begin
        logic holdoff_done;
        holdoff_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (holdoff_req && !holdoff_done) begin
                m_ready <= 1'b0;
                repeat (HOLDOFF_LEN - 1) @(posedge aclk);
                holdoff_done = 1'b1;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
